@@ sv/amwd_pkg.sv @@
package amwd_pkg;

  localparam int WINDOW    = 30;
  localparam int PTR_W     = $clog2(WINDOW);
  localparam int ACC_W     = 13;
  localparam int SQ_W      = 2 * ACC_W - 1;
  localparam int DEV_W     = 26;
  localparam int SUM_W     = DEV_W + PTR_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = DEV_W;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 48;
  localparam int OUT_PAD   = OUT_W - (2 + 1 + 3 * ACC_W);

  localparam logic [DEV_W-1:0] MEAN_THRESHOLD_RST  = 26'd450000;
  localparam logic [DEV_W-1:0] GRAVITY_SQUARED_RST = 26'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN_THRESHOLD  = 1'b0,
    REG_GRAVITY_SQUARED = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2
  } event_t;

  // stage load enables for the deviation datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } amwd_adv_t;

endpackage

@@ sv/amwd_ring.sv @@
module amwd_ring import amwd_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [PTR_W-1:0] wr_addr,
  input  logic [DEV_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [PTR_W-1:0] rd_addr,
  output logic [DEV_W-1:0] rd_data
);

  logic [DEV_W-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/amwd_dev.sv @@
module amwd_dev import amwd_pkg::*; (
  input  logic                    clk,
  input  amwd_adv_t               adv,
  input  logic signed [ACC_W-1:0] accel_x,
  input  logic signed [ACC_W-1:0] accel_y,
  input  logic signed [ACC_W-1:0] accel_z,
  input  logic        [DEV_W-1:0] gravity_squared,
  output logic        [DEV_W-1:0] dev,
  output logic signed [ACC_W-1:0] echo_x,
  output logic signed [ACC_W-1:0] echo_y,
  output logic signed [ACC_W-1:0] echo_z
);

  logic signed [ACC_W-1:0]   x1, y1, z1;
  logic signed [ACC_W-1:0]   x2, y2, z2;
  logic        [SQ_W-1:0]    sqx, sqy, sqz;
  logic signed [2*ACC_W-1:0] px, py, pz;
  logic        [DEV_W-1:0]   mag;
  logic        [DEV_W-1:0]   dev_next;

  assign px = x1 * x1;
  assign py = y1 * y1;
  assign pz = z1 * z1;

  always_comb begin
    mag = DEV_W'(sqx) + DEV_W'(sqy) + DEV_W'(sqz);
    if (mag >= gravity_squared) begin
      dev_next = mag - gravity_squared;
    end else begin
      dev_next = gravity_squared - mag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      x1 <= accel_x;
      y1 <= accel_y;
      z1 <= accel_z;
    end
    if (adv.s2) begin
      sqx <= px[SQ_W-1:0];
      sqy <= py[SQ_W-1:0];
      sqz <= pz[SQ_W-1:0];
      x2  <= x1;
      y2  <= y1;
      z2  <= z1;
    end
    if (adv.s3) begin
      dev    <= dev_next;
      echo_x <= x2;
      echo_y <= y2;
      echo_z <= z2;
    end
  end

endmodule

@@ sv/accel_motion_window_detector_core.sv @@
// Motion window detector: one three-axis accelerometer sample in, one result out.
// Input item on s_axis: x, y and z in milli-g, 13-bit two's complement each.
// Result item on m_axis: event code (none, start, stop), the active flag and the
// sample echoed while active; tuser carries the progress flag.
// Each sample's deviation from rest goes into a ring memory of WINDOW entries
// and a running sum; the window mean is compared with mean_threshold once the
// ring has been filled for the first time.
// An accepted item passes the input, square, deviation, window and output
// registers. Throughput is one item per cycle unless the output stalls; the ring
// is read one stage ahead of its write; sum and active flag update in one step.
// Every stage holds its own item, so input is still accepted while a result waits
// as long as an earlier stage has room; a stalled receiver fills the stages one
// by one and only then drops s_axis_tready.
// Reset (synchronous, rst high) empties the pipeline, loads the register reset
// values and marks the ring as unfilled, so it reads as zero until its first
// wrap; no clearing pass is needed. The user must write configuration through
// cfg_we, cfg_index and cfg_data only while idle; the block does not enforce it.
module accel_motion_window_detector_core import amwd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // accel_x, accel_y, accel_z, zero padding
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // event_code, active, echo_x, echo_y, echo_z, zero padding
  output logic [OUT_W-1:0]     m_axis_tdata,
  // progress_valid
  output logic                 m_axis_tuser
);

  logic [DEV_W-1:0] mean_threshold;
  logic [DEV_W-1:0] gravity_squared;
  logic [SUM_W-1:0] thr_cmp;

  logic [PTR_W-1:0] write_index;
  logic             window_full;
  logic             active_flag;
  logic [SUM_W-1:0] window_sum;

  logic v1, v2, v3, v4, out_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic load1, load3, load4, load5;
  amwd_adv_t adv;

  logic [PTR_W-1:0] slot1, slot2, slot3;
  logic             old_ok;
  logic [DEV_W-1:0] rd_data;
  logic [DEV_W-1:0] old_dev;
  logic [DEV_W-1:0] dev3;
  logic signed [ACC_W-1:0] x3, y3, z3;
  logic signed [ACC_W-1:0] x4, y4, z4;
  logic             full3;
  logic             full4;
  logic             above;
  logic             active_next;
  event_t           event_next;

  event_t                  out_event;
  logic                    out_active;
  logic signed [ACC_W-1:0] out_x, out_y, out_z;

  // ready chain with bubble collapse
  assign rdy5  = !out_valid || m_axis_tready;
  assign rdy4  = !v4 || rdy5;
  assign rdy3  = !v3 || rdy4;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;
  assign load1 = s_axis_tvalid && rdy1;
  assign load3 = v2 && rdy3;
  assign load4 = v3 && rdy4;
  assign load5 = v4 && rdy5;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_threshold  <= MEAN_THRESHOLD_RST;
      gravity_squared <= GRAVITY_SQUARED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MEAN_THRESHOLD:  mean_threshold  <= cfg_data;
        REG_GRAVITY_SQUARED: gravity_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  // mean > threshold is the same as sum > WINDOW * threshold + WINDOW - 1
  always_ff @(posedge clk) begin
    thr_cmp <= SUM_W'(mean_threshold) * SUM_W'(WINDOW) + SUM_W'(WINDOW - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  amwd_dev u_dev (
    .clk             (clk),
    .adv             (adv),
    .accel_x         (s_axis_tdata[ACC_W-1:0]),
    .accel_y         (s_axis_tdata[2*ACC_W-1:ACC_W]),
    .accel_z         (s_axis_tdata[3*ACC_W-1:2*ACC_W]),
    .gravity_squared (gravity_squared),
    .dev             (dev3),
    .echo_x          (x3),
    .echo_y          (y3),
    .echo_z          (z3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
    end else if (load1) begin
      if (write_index == PTR_W'(WINDOW - 1)) begin
        write_index <= '0;
      end else begin
        write_index <= write_index + PTR_W'(1);
      end
    end
  end

  // the item ahead may be the one that completes the first fill
  always_ff @(posedge clk) begin
    if (rdy1) slot1 <= write_index;
    if (rdy2) slot2 <= slot1;
    if (rdy3) slot3 <= slot2;
    if (load3) old_ok <= window_full || (load4 && full3);
  end

  amwd_ring u_ring (
    .clk     (clk),
    .wr_en   (load4),
    .wr_addr (slot3),
    .wr_data (dev3),
    .rd_en   (load3),
    .rd_addr (slot2),
    .rd_data (rd_data)
  );

  // entries not yet written since reset read as zero
  assign old_dev = old_ok ? rd_data : '0;
  assign full3   = window_full || (slot3 == PTR_W'(WINDOW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      window_full <= 1'b0;
      window_sum  <= '0;
    end else if (load4) begin
      window_full <= full3;
      window_sum  <= window_sum - SUM_W'(old_dev) + SUM_W'(dev3);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      full4 <= full3;
      x4    <= x3;
      y4    <= y3;
      z4    <= z3;
    end
  end

  always_comb begin
    above       = window_sum > thr_cmp;
    active_next = active_flag;
    event_next  = EV_NONE;
    if (full4) begin
      if (above && !active_flag) begin
        active_next = 1'b1;
        event_next  = EV_START;
      end else if (!above && active_flag) begin
        active_next = 1'b0;
        event_next  = EV_STOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag <= 1'b0;
    end else if (load5) begin
      active_flag <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_event  <= event_next;
      out_active <= active_next;
      out_x      <= active_next ? x4 : '0;
      out_y      <= active_next ? y4 : '0;
      out_z      <= active_next ? z4 : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_z, out_y, out_x, out_active, out_event};
  assign m_axis_tuser  = out_active;

endmodule

@@ sv/amwd_checker.sv @@
module amwd_checker import amwd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  logic [1:0] ev;
  logic       act;

  assign ev  = m_axis_tdata[1:0];
  assign act = m_axis_tdata[2];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result item after reset");

  a_event_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ev == EV_START |-> act)
    else $error("start event without active flag");

  a_stop_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ev == EV_STOP |-> !act)
    else $error("stop event with active flag");

  a_echo_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == act) &&
                      (act || m_axis_tdata[3*ACC_W+2:3] == '0))
    else $error("progress flag or echo inconsistent");

endmodule

bind accel_motion_window_detector_core amwd_checker u_amwd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import amwd_pkg::*;

  typedef struct packed {
    event_t                  code;
    logic                    act;
    logic                    prog;
    logic signed [ACC_W-1:0] ex;
    logic signed [ACC_W-1:0] ey;
    logic signed [ACC_W-1:0] ez;
  } motion_result_t;

  class motion_scoreboard;
    longint         threshold  = MEAN_THRESHOLD_RST;
    longint         gravity_sq = GRAVITY_SQUARED_RST;
    longint         ring [WINDOW];
    int             slot;
    bit             filled;
    bit             active;
    longint         run_sum;
    motion_result_t pending_q [$];
    int             errors;
    int             samples_seen;
    int             results_seen;
    int             starts;
    int             stops;

    function void set_register(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_MEAN_THRESHOLD:  threshold  = val;
        REG_GRAVITY_SQUARED: gravity_sq = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [ACC_W-1:0] ax, logic signed [ACC_W-1:0] ay,
                              logic signed [ACC_W-1:0] az);
      longint         mag;
      longint         diff;
      longint         mean;
      motion_result_t r;
      mag = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
          + longint'(az) * longint'(az);
      diff = mag - gravity_sq;
      if (diff < 0) begin
        diff = -diff;
      end
      diff = diff & 64'h3FF_FFFF;
      run_sum = run_sum - ring[slot] + diff;
      ring[slot] = diff;
      if (slot == WINDOW - 1) begin
        filled = 1'b1;
      end
      r.code = EV_NONE;
      if (filled) begin
        mean = run_sum / WINDOW;
        if (mean > threshold && !active) begin
          active = 1'b1;
          r.code = EV_START;
          starts++;
        end else if (mean <= threshold && active) begin
          active = 1'b0;
          r.code = EV_STOP;
          stops++;
        end
      end
      slot = (slot == WINDOW - 1) ? 0 : slot + 1;
      r.act  = active;
      r.prog = active;
      r.ex   = active ? ax : '0;
      r.ey   = active ? ay : '0;
      r.ez   = active ? az : '0;
      pending_q.push_back(r);
      samples_seen++;
    endfunction

    function void flag_field(string name, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic user);
      motion_result_t want;
      motion_result_t got;
      got.code = event_t'(data[1:0]);
      got.act  = data[2];
      got.ex   = data[3 +: ACC_W];
      got.ey   = data[3 + ACC_W +: ACC_W];
      got.ez   = data[3 + 2 * ACC_W +: ACC_W];
      got.prog = user;
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected nothing actual %h", $time, data);
        return;
      end
      want = pending_q.pop_front();
      if (got.code != want.code) flag_field("event_code", want.code, got.code);
      if (got.act != want.act) flag_field("active", want.act, got.act);
      if (got.prog != want.prog) flag_field("progress_valid", want.prog, got.prog);
      if (got.ex != want.ex) flag_field("echo_x", want.ex, got.ex);
      if (got.ey != want.ey) flag_field("echo_y", want.ey, got.ey);
      if (got.ez != want.ez) flag_field("echo_z", want.ez, got.ez);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // accel_x, accel_y, accel_z, zero padding
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // event_code, active, echo_x, echo_y, echo_z, zero padding
  logic [OUT_W-1:0]     m_axis_tdata;
  // progress_valid
  logic                 m_axis_tuser;

  motion_scoreboard board = new;
  bit               idle_on = 1'b1;
  bit               hold_done = 1'b0;
  int               settings_used = 1;

  accel_motion_window_detector_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // receiver: random stalls plus one long hold-off to back the pipeline up
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && !hold_done && board.results_seen >= 150) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic signed [ACC_W-1:0] pick(int lo, int hi);
    return ACC_W'($urandom_range(0, hi - lo) + lo);
  endfunction

  task automatic send_sample(input logic signed [ACC_W-1:0] ax,
                             input logic signed [ACC_W-1:0] ay,
                             input logic signed [ACC_W-1:0] az);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - 3 * ACC_W){1'b0}}, az, ay, ax};
    do @(posedge clk); while (!s_axis_tready);
    board.note_sample(ax, ay, az);
    @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    board.set_register(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] grav);
    write_register(REG_MEAN_THRESHOLD, thr);
    write_register(REG_GRAVITY_SQUARED, grav);
    settings_used++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // quiet stretches near rest followed by bursts of shaking, with some noise
  task automatic run_motion(input int count, input int rest);
    int sent;
    int len;
    int i;
    int lo;
    int hi;
    logic signed [ACC_W-1:0] main_axis;
    sent = 0;
    lo = rest - 80;
    hi = (rest + 80 > 4095) ? 4095 : rest + 80;
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) begin
          send_sample(pick(-4096, 4095), pick(-4096, 4095), pick(-4096, 4095));
        end
      end else begin
        len = $urandom_range(5, 40);
        for (i = 0; i < len; i++) begin
          main_axis = pick(lo, hi);
          if ($urandom_range(0, 1)) main_axis = -main_axis;
          case ($urandom_range(0, 2))
            0: send_sample(main_axis, pick(-150, 150), pick(-150, 150));
            1: send_sample(pick(-150, 150), main_axis, pick(-150, 150));
            default: send_sample(pick(-150, 150), pick(-150, 150), main_axis);
          endcase
        end
        sent += len;
        len = $urandom_range(1, 35);
        for (i = 0; i < len; i++) begin
          send_sample(pick(-4000, 4000), pick(-4000, 4000), pick(-4000, 4000));
        end
      end
      sent += len;
    end
  endtask

  initial begin
    int i;
    int rest;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes and exact rest, window still filling
    send_sample(13'sd0, 13'sd0, 13'sd0);
    send_sample(13'sd4095, 13'sd4095, 13'sd4095);
    send_sample(-13'sd4096, -13'sd4096, -13'sd4096);
    send_sample(13'sd4000, -13'sd4000, 13'sd4000);
    send_sample(-13'sd4000, 13'sd4000, -13'sd4000);
    send_sample(13'sd1000, 13'sd0, 13'sd0);
    send_sample(13'sd0, -13'sd1000, 13'sd0);
    send_sample(13'sd0, 13'sd0, 13'sd1000);
    send_sample(13'sd4095, -13'sd4096, 13'sd0);
    send_sample(-13'sd1, -13'sd1, -13'sd1);
    send_sample(13'sd1, 13'sd1, 13'sd1);
    send_sample(-13'sd4096, 13'sd0, 13'sd4095);
    for (i = 0; i < 13; i++) begin
      send_sample(-13'sd4000, 13'sd4000, 13'sd4000);
    end
    run_motion(280, 1000);
    drain;

    // everything above zero counts, then an all-zero window to drop out
    set_window(26'd0, 26'd0);
    run_motion(60, 1000);
    for (i = 0; i < 35; i++) begin
      send_sample(13'sd0, 13'sd0, 13'sd0);
    end
    for (i = 0; i < 10; i++) begin
      send_sample(pick(-4096, 4095), pick(-4096, 4095), pick(-4096, 4095));
    end
    drain;

    set_window(26'h3FF_FFFF, 26'h3FF_FFFF);
    run_motion(60, 1000);
    drain;

    idle_on = $urandom_range(0, 1);
    set_window(26'd200000, 26'd4000000);
    run_motion(240, 2000);
    drain;

    for (i = 0; i < 3; i++) begin
      idle_on = $urandom_range(0, 2) != 0;
      rest = $urandom_range(500, 3000);
      set_window(CFG_W'($urandom_range(20000, 2000000)), CFG_W'(rest * rest));
      run_motion(130, rest);
      drain;
    end

    // back to the power-on setting, no idling from here on
    idle_on = 1'b0;
    set_window(MEAN_THRESHOLD_RST, GRAVITY_SQUARED_RST);
    run_motion(250, 1000);
    drain;

    $display("run covered %0d samples over %0d threshold settings",
             board.samples_seen, settings_used);
    $display("detector raised %0d start and %0d stop events, %0d results checked",
             board.starts, board.stops, board.results_seen);
    if (board.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
